@@ src/rrle_pkg.sv @@
// Shared types and constants for the row run-length encoder.
// Holds the command format passed from the front part to the back part.
// No dependencies.
`default_nettype none

package rrle_pkg;

    localparam int SYM_W         = 8;
    localparam int RUN_CW        = 8;
    localparam int RUN_MIN       = 3;
    localparam int RUN_LIMIT8    = 130;
    localparam int RUN_LIMIT4    = 10;
    localparam int RUN_BASE8     = 128;
    localparam int RUN_BASE4     = 8;
    localparam int RAW_LIMIT4    = 8;
    localparam int RAW_DEPTH_DEF = 128;
    localparam int CMD_DEPTH     = 4;
    localparam int LANES         = 8;
    localparam int LANE_CW       = 4;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_FLUSH,
        CMD_RUN,
        CMD_END
    } t_cmd_kind;

    // command from the front part; byte_a is the pixel or run header
    typedef struct packed {
        t_cmd_kind        kind;
        logic             flush;
        logic [SYM_W-1:0] byte_a;
        logic [SYM_W-1:0] byte_b;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_CHANGE,
        PH_LIMIT,
        PH_ROW
    } t_phase;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_ADVANCE,
        FS_CLOSE,
        FS_RAWEND,
        FS_END
    } t_fstate;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_HDR,
        BS_RD,
        BS_DATA,
        BS_RUN1,
        BS_RUN2,
        BS_END
    } t_bstate;

endpackage

`default_nettype wire

@@ src/row_run_length_encoder_unit.sv @@
// Row run-length encoder with packet output, 8-bit or 4-bit packet form.
// Slave stream in: one pixel per item, tlast marks the last pixel of a row.
// Master stream out: up to 8 packet bytes per item, first byte lowest;
// tlast marks the final item caused by one input pixel.
// Config channel: writes nibble_mode and clears the pending run and raw string.
// The front sequencer accepts a pixel, then issues its commands one at a
// time, with a step between close phases; it waits while the queue is full.
// The back part writes the store on a raw add, sends the packer's word on an
// end command, sends a raw packet as its header and then each pixel read back
// from the store, and sends a run packet as its header and pixel. The 4-entry
// command queue lets the front take the next pixel while the back still drains
// earlier packets. Reset (synchronous, active low) empties the queue and the
// packer and selects the 8-bit form; the store needs no clearing. When the
// receiver stalls, the output word holds, the packer and then the queue fill,
// and the slave side deasserts tready.
// Depends on rrle_pkg, rrle_front, rrle_cmd_fifo, rrle_back, rrle_ram.
`default_nettype none

module row_run_length_encoder_unit
    import rrle_pkg::*;
#(
    parameter int RAW_DEPTH = RAW_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // pixel[7:0]
    input  wire logic        s_axis_tlast,   // row_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // symbols[63:0], symbol_count[67:64], zero pad
    output logic             m_axis_tlast,   // last
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data      // nibble_mode
);

    logic                        r_nibble;
    logic                        cfg_wr;
    logic                        push, pop, full, empty;
    t_cmd                        cmd_in, cmd_out;
    logic [LANES-1:0][SYM_W-1:0] symbols;
    logic [LANE_CW-1:0]          sym_cnt;

    assign o_cfg_ready = i_rst_n;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nibble <= 1'b0;
        end else if (cfg_wr) begin
            r_nibble <= i_cfg_data;
        end
    end

    rrle_front #(
        .RAW_DEPTH (RAW_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (cfg_wr),
        .i_nibble  (r_nibble),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_pixel   (s_axis_tdata),
        .i_row_end (s_axis_tlast),
        .o_push    (push),
        .o_cmd     (cmd_in),
        .i_full    (full)
    );

    rrle_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (empty)
    );

    rrle_back #(
        .RAW_DEPTH (RAW_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (cfg_wr),
        .i_cmd     (cmd_out),
        .i_empty   (empty),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_symbols (symbols),
        .o_count   (sym_cnt),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, sym_cnt, symbols};

endmodule

`default_nettype wire

@@ src/rrle_ram.sv @@
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module rrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/rrle_cmd_fifo.sv @@
// Short command queue between the front and back parts.
// Depends on rrle_pkg.
`default_nettype none

module rrle_cmd_fifo
    import rrle_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push && !o_full) - CW'(i_pop && !o_empty);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into full queue");
`endif

endmodule

`default_nettype wire

@@ src/rrle_front.sv @@
// Front part: accepts pixels, tracks run and raw lengths, issues commands.
// Depends on rrle_pkg.
`default_nettype none

module rrle_front
    import rrle_pkg::*;
#(
    parameter int RAW_DEPTH = RAW_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clr,
    input  wire logic             i_nibble,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [SYM_W-1:0] i_pixel,
    input  wire logic             i_row_end,
    output logic                  o_push,
    output t_cmd                  o_cmd,
    input  wire logic             i_full
);

    localparam int RAW_CW = $clog2(RAW_DEPTH + 1);

    t_fstate            r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [RUN_CW-1:0]  r_run_cnt, n_run_cnt;
    logic [SYM_W-1:0]   r_run_pix, n_run_pix;
    logic [RAW_CW-1:0]  r_raw_cnt, n_raw_cnt;
    logic [SYM_W-1:0]   r_pin, n_pin;
    logic               r_re, n_re;

    logic [RAW_CW-1:0]  raw_lim, raw_inc;
    logic [RUN_CW-1:0]  run_lim, run_inc, run_ofs;
    logic [SYM_W-1:0]   pix_m;

    assign raw_lim = i_nibble ? RAW_CW'(RAW_LIMIT4) : RAW_CW'(RAW_DEPTH);
    assign run_lim = i_nibble ? RUN_CW'(RUN_LIMIT4) : RUN_CW'(RUN_LIMIT8);
    assign run_ofs = i_nibble ? RUN_CW'(RUN_BASE4 - RUN_MIN) : RUN_CW'(RUN_BASE8 - RUN_MIN);
    assign raw_inc = r_raw_cnt + 1'b1;
    assign run_inc = r_run_cnt + 1'b1;
    assign pix_m   = i_nibble ? {4'b0000, i_pixel[3:0]} : i_pixel;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_state   <= FS_IDLE;
            r_phase   <= PH_CHANGE;
            r_run_cnt <= '0;
            r_run_pix <= '0;
            r_raw_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_run_cnt <= n_run_cnt;
            r_run_pix <= n_run_pix;
            r_raw_cnt <= n_raw_cnt;
        end
    end

    // latched item
    always_ff @(posedge i_clk) begin
        r_pin <= n_pin;
        r_re  <= n_re;
    end

    // sequencer: at most one command per cycle, held while the queue is full
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_run_cnt = r_run_cnt;
        n_run_pix = r_run_pix;
        n_raw_cnt = r_raw_cnt;
        n_pin     = r_pin;
        n_re      = r_re;
        o_ready   = 1'b0;
        o_push    = 1'b0;
        o_cmd     = '0;
        case (r_state)
            FS_IDLE: begin
                o_ready = i_rst_n;
                if (i_valid) begin
                    n_pin = pix_m;
                    n_re  = i_row_end;
                    if (r_run_cnt != '0 && pix_m != r_run_pix) begin
                        n_state = FS_CLOSE;
                        n_phase = PH_CHANGE;
                    end else begin
                        n_state = FS_ADVANCE;
                    end
                end
            end
            FS_ADVANCE: begin
                n_run_pix = r_pin;
                n_run_cnt = run_inc;
                if (run_inc >= run_lim) begin
                    n_state = FS_CLOSE;
                    n_phase = PH_LIMIT;
                end else if (r_re) begin
                    n_state = FS_CLOSE;
                    n_phase = PH_ROW;
                end else begin
                    n_state = FS_END;
                end
            end
            FS_CLOSE: begin
                if (r_run_cnt == '0) begin
                    case (r_phase)
                        PH_CHANGE: n_state = FS_ADVANCE;
                        PH_LIMIT: begin
                            if (r_re) begin
                                n_phase = PH_ROW;
                            end else begin
                                n_state = FS_END;
                            end
                        end
                        default: n_state = FS_RAWEND;
                    endcase
                end else if (!i_full) begin
                    o_push = 1'b1;
                    if (r_run_cnt < RUN_CW'(RUN_MIN)) begin
                        // short run joins the raw string
                        o_cmd.kind   = CMD_ADD;
                        o_cmd.flush  = (raw_inc >= raw_lim);
                        o_cmd.byte_a = r_run_pix;
                        n_raw_cnt    = (raw_inc >= raw_lim) ? '0 : raw_inc;
                        n_run_cnt    = r_run_cnt - 1'b1;
                    end else if (r_raw_cnt != '0) begin
                        o_cmd.kind = CMD_FLUSH;
                        n_raw_cnt  = '0;
                    end else begin
                        o_cmd.kind   = CMD_RUN;
                        o_cmd.byte_a = r_run_cnt + run_ofs;
                        o_cmd.byte_b = r_run_pix;
                        n_run_cnt    = '0;
                    end
                end
            end
            FS_RAWEND: begin
                if (r_raw_cnt == '0) begin
                    n_state = FS_END;
                end else if (!i_full) begin
                    o_push     = 1'b1;
                    o_cmd.kind = CMD_FLUSH;
                    n_raw_cnt  = '0;
                    n_state    = FS_END;
                end
            end
            FS_END: begin
                if (!i_full) begin
                    o_push     = 1'b1;
                    o_cmd.kind = CMD_END;
                    n_state    = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_cnt <= RUN_CW'(RUN_LIMIT8) && r_raw_cnt < RAW_CW'(RAW_DEPTH))
        else $error("run or raw count out of range");
`endif

endmodule

`default_nettype wire

@@ src/rrle_back.sv @@
// Back part: executes commands, keeps the raw pixel store, packs output bytes.
// Depends on rrle_pkg and rrle_ram.
`default_nettype none

module rrle_back
    import rrle_pkg::*;
#(
    parameter int RAW_DEPTH = RAW_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_clr,
    input  wire t_cmd                         i_cmd,
    input  wire logic                         i_empty,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [LANES-1:0][SYM_W-1:0]       o_symbols,
    output logic [LANE_CW-1:0]                o_count,
    output logic                              o_last
);

    localparam int RAW_CW = $clog2(RAW_DEPTH + 1);
    localparam int AW     = $clog2(RAW_DEPTH);

    t_bstate                     r_state, n_state;
    logic [RAW_CW-1:0]           r_raw, n_raw;
    logic [AW-1:0]               r_idx, n_idx;
    logic [SYM_W-1:0]            r_ba, n_ba, r_bb, n_bb;
    logic [LANES-1:0][SYM_W-1:0] r_buf, n_buf, r_od, n_od;
    logic [LANE_CW-1:0]          r_pk, n_pk, r_ocnt, n_ocnt;
    logic                        r_ov, n_ov, r_olast, n_olast;

    logic                        ram_we;
    logic [SYM_W-1:0]            ram_rdata;
    logic                        sink_v, sink_ok, out_free;
    logic [SYM_W-1:0]            sink_b;

    rrle_ram #(
        .WIDTH (SYM_W),
        .DEPTH (RAW_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_raw[AW-1:0]),
        .i_wdata (i_cmd.byte_a),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_ov || i_ready;
    assign sink_ok  = (r_pk != LANE_CW'(LANES)) || out_free;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_raw   <= '0;
            r_pk    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_raw   <= i_clr ? '0 : n_raw;
            r_pk    <= n_pk;
            r_ov    <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_ba    <= n_ba;
        r_bb    <= n_bb;
        r_buf   <= (!i_rst_n) ? '0 : n_buf;
        r_od    <= n_od;
        r_ocnt  <= n_ocnt;
        r_olast <= n_olast;
    end

    // command execution and byte packing
    always_comb begin
        n_state = r_state;
        n_raw   = r_raw;
        n_idx   = r_idx;
        n_ba    = r_ba;
        n_bb    = r_bb;
        n_buf   = r_buf;
        n_pk    = r_pk;
        n_od    = r_od;
        n_ocnt  = r_ocnt;
        n_olast = r_olast;
        n_ov    = r_ov && !i_ready;
        o_pop   = 1'b0;
        ram_we  = 1'b0;
        sink_v  = 1'b0;
        sink_b  = '0;
        case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_ADD: begin
                            ram_we = 1'b1;
                            n_raw  = r_raw + 1'b1;
                            if (i_cmd.flush) begin
                                n_state = BS_HDR;
                            end
                        end
                        CMD_FLUSH: n_state = BS_HDR;
                        CMD_RUN: begin
                            n_ba    = i_cmd.byte_a;
                            n_bb    = i_cmd.byte_b;
                            n_state = BS_RUN1;
                        end
                        default: n_state = BS_END;
                    endcase
                end
            end
            BS_HDR: begin
                sink_v = 1'b1;
                sink_b = SYM_W'(r_raw - 1'b1);
                if (sink_ok) begin
                    n_idx   = '0;
                    n_state = BS_RD;
                end
            end
            BS_RD: n_state = BS_DATA;
            BS_DATA: begin
                sink_v = 1'b1;
                sink_b = ram_rdata;
                if (sink_ok) begin
                    if (RAW_CW'(r_idx) + 1'b1 == r_raw) begin
                        n_raw   = '0;
                        n_state = BS_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = BS_RD;
                    end
                end
            end
            BS_RUN1: begin
                sink_v = 1'b1;
                sink_b = r_ba;
                if (sink_ok) begin
                    n_state = BS_RUN2;
                end
            end
            BS_RUN2: begin
                sink_v = 1'b1;
                sink_b = r_bb;
                if (sink_ok) begin
                    n_state = BS_IDLE;
                end
            end
            BS_END: begin
                // close the step: the last word, partial or full, carries the last flag
                if (r_pk == '0) begin
                    n_state = BS_IDLE;
                end else if (out_free) begin
                    n_od    = r_buf;
                    n_ocnt  = r_pk;
                    n_olast = 1'b1;
                    n_ov    = 1'b1;
                    n_buf   = '0;
                    n_pk    = '0;
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase

        // packer: a full word leaves when another byte follows it or at an end command
        if (sink_v && sink_ok) begin
            if (r_pk == LANE_CW'(LANES)) begin
                n_od     = r_buf;
                n_ocnt   = LANE_CW'(LANES);
                n_olast  = 1'b0;
                n_ov     = 1'b1;
                n_buf    = '0;
                n_buf[0] = sink_b;
                n_pk     = LANE_CW'(1);
            end else begin
                for (int i = 0; i < LANES; i++) begin
                    if (LANE_CW'(i) == r_pk) begin
                        n_buf[i] = sink_b;
                    end
                end
                n_pk = r_pk + 1'b1;
            end
        end
    end

    assign o_valid   = r_ov;
    assign o_symbols = r_od;
    assign o_count   = r_ocnt;
    assign o_last    = r_olast;

`ifndef SYNTHESIS
    a_pack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pk <= LANE_CW'(LANES))
        else $error("packer count out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_od) && $stable(r_olast)))
        else $error("stalled result word changed");
`endif

endmodule

`default_nettype wire
